[design/bdlp_pkg.sv]
// Package: event codes, level codes, register map and reset values for the debounce core.
package bdlp_pkg;

    // Event codes carried in the result transaction
    typedef logic [1:0] event_code_t;
    localparam event_code_t EV_NONE  = 2'd0;
    localparam event_code_t EV_SHORT = 2'd1;
    localparam event_code_t EV_LONG  = 2'd2;
    localparam event_code_t EV_RAMP  = 2'd3;

    // Button levels (active low)
    localparam logic LEVEL_PRESSED  = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

    // Counter widths and saturation limit
    localparam int unsigned DEB_W  = 8;
    localparam int unsigned HOLD_W = 16;
    localparam int unsigned DIV_W  = 8;
    localparam logic [HOLD_W-1:0] HOLD_MAX = 16'hFFFF;

    // Register map: index = paddr[3:2]
    localparam int unsigned ADDR_W = 4;
    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_DEBOUNCE_TICKS   = 2'd0;
    localparam reg_idx_t REG_LONG_PRESS_TICKS = 2'd1;
    localparam reg_idx_t REG_RAMP_INTERVAL    = 2'd2;

    // Register reset values
    localparam logic [DEB_W-1:0]  DEBOUNCE_TICKS_RST   = 8'd4;
    localparam logic [HOLD_W-1:0] LONG_PRESS_TICKS_RST = 16'd100;
    localparam logic [DIV_W-1:0]  RAMP_INTERVAL_RST    = 8'd4;

endpackage

[design/button_debounce_long_press_core.sv]
// Button debouncer with short press, long press and ramp-step event detection.
//
// Each input transaction is one tick carrying the raw active-low button level;
// each produces exactly one result transaction with an event code and the
// debounced level. The core takes one tick per cycle when the result is not
// stalled: a tick is held in an input register, then one pass of counter
// compares and increments updates the debounce, hold and ramp state and loads
// the result register. A stalled result does not block input acceptance until
// both the input and result registers are full.
// Configuration registers (APB, byte addresses 0x0, 0x4, 0x8) must be written
// only while no ticks are in flight.
module button_debounce_long_press_core
    import bdlp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Tick input
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [0] raw_level, [7:1] zero
    // Result output
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [1:0] event_code, [2] pressed_level, [7:3] zero
    // APB configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Configuration registers
    logic [DEB_W-1:0]  debounce_ticks_reg;
    logic [HOLD_W-1:0] long_press_ticks_reg;
    logic [DIV_W-1:0]  ramp_interval_reg;

    // Pipeline registers
    logic              in_valid_reg;
    logic              in_level_reg;
    logic              out_valid_reg;
    event_code_t       out_event_reg;
    logic              out_level_reg;

    // Button state
    logic              stable_level_reg,   stable_level_next;
    logic [DEB_W-1:0]  mismatch_count_reg, mismatch_count_next;
    logic [HOLD_W-1:0] hold_count_reg,     hold_count_next;
    logic              ramp_active_reg,    ramp_active_next;
    logic [DIV_W-1:0]  ramp_divider_reg,   ramp_divider_next;
    event_code_t       event_next;

    logic              s_accept;
    logic              advance;
    logic              cfg_write;
    reg_idx_t          cfg_idx;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_level_reg, out_event_reg};

    // APB access
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (cfg_idx)
            REG_DEBOUNCE_TICKS:   prdata = {24'd0, debounce_ticks_reg};
            REG_LONG_PRESS_TICKS: prdata = {16'd0, long_press_ticks_reg};
            REG_RAMP_INTERVAL:    prdata = {24'd0, ramp_interval_reg};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg   <= DEBOUNCE_TICKS_RST;
            long_press_ticks_reg <= LONG_PRESS_TICKS_RST;
            ramp_interval_reg    <= RAMP_INTERVAL_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_DEBOUNCE_TICKS:   debounce_ticks_reg   <= pwdata[DEB_W-1:0];
                REG_LONG_PRESS_TICKS: long_press_ticks_reg <= pwdata[HOLD_W-1:0];
                REG_RAMP_INTERVAL:    ramp_interval_reg    <= pwdata[DIV_W-1:0];
                default:              ;
            endcase
        end
    end

    // Debounce, hold and ramp update for the tick in the input register
    always_comb
    begin
        logic [DEB_W-1:0] mc_inc;
        logic [DIV_W-1:0] div_inc;

        stable_level_next   = stable_level_reg;
        mismatch_count_next = mismatch_count_reg;
        hold_count_next     = hold_count_reg;
        ramp_active_next    = ramp_active_reg;
        ramp_divider_next   = ramp_divider_reg;
        event_next          = EV_NONE;
        mc_inc              = mismatch_count_reg + DEB_W'(1);
        div_inc             = ramp_divider_reg + DIV_W'(1);

        // Level change after a full mismatch streak
        if (in_level_reg != stable_level_reg)
        begin
            mismatch_count_next = mc_inc;
            if (mc_inc >= debounce_ticks_reg)
            begin
                mismatch_count_next = '0;
                stable_level_next   = in_level_reg;
                if (in_level_reg == LEVEL_PRESSED)
                begin
                    hold_count_next   = '0;
                    ramp_active_next  = 1'b0;
                    ramp_divider_next = '0;
                end
                else
                begin
                    event_next       = ramp_active_reg ? EV_LONG : EV_SHORT;
                    ramp_active_next = 1'b0;
                end
            end
        end
        else
        begin
            mismatch_count_next = '0;
        end

        // Hold counting and ramp steps while pressed
        if (stable_level_next == LEVEL_PRESSED)
        begin
            if (hold_count_next < HOLD_MAX)
            begin
                hold_count_next = hold_count_next + HOLD_W'(1);
            end
            if (!ramp_active_next)
            begin
                if (hold_count_next >= long_press_ticks_reg)
                begin
                    ramp_active_next  = 1'b1;
                    ramp_divider_next = '0;
                end
            end
            else
            begin
                // ramp was active before this tick, so divider is unchanged
                ramp_divider_next = div_inc;
                if (div_inc >= ramp_interval_reg)
                begin
                    ramp_divider_next = '0;
                    event_next        = EV_RAMP;
                end
            end
        end
    end

    // Pipeline control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            stable_level_reg   <= LEVEL_RELEASED;
            mismatch_count_reg <= '0;
            hold_count_reg     <= '0;
            ramp_active_reg    <= 1'b0;
            ramp_divider_reg   <= '0;
        end
        else
        begin
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg      <= 1'b1;
                stable_level_reg   <= stable_level_next;
                mismatch_count_reg <= mismatch_count_next;
                hold_count_reg     <= hold_count_next;
                ramp_active_reg    <= ramp_active_next;
                ramp_divider_reg   <= ramp_divider_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_level_reg <= s_tdata[0];
        end
        if (advance)
        begin
            out_event_reg <= event_next;
            out_level_reg <= stable_level_next;
        end
    end

    // Ramp steps are only reported while the button is held
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_event_reg == EV_RAMP) |-> out_level_reg == LEVEL_PRESSED)
        else $error("ramp step reported with button released");

    // Press-end events are only reported with the button released
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ((out_event_reg == EV_SHORT) || (out_event_reg == EV_LONG))
        |-> out_level_reg == LEVEL_RELEASED)
        else $error("press end reported with button still held");

    // Ramping is never left active after a release
    assert property (@(posedge clk) disable iff (!rst_n)
        ramp_active_reg |-> stable_level_reg == LEVEL_PRESSED)
        else $error("ramp active while released");

    // An empty result register never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

[verif/tb_button_debounce_long_press_core.sv]
// Testbench for the button debounce core: directed and random tick streams checked against a predictor.
module tb_button_debounce_long_press_core
    import bdlp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Register index with no register behind it
    localparam reg_idx_t REG_UNUSED = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;   // [0] raw_level, [7:1] zero
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;   // [1:0] event_code, [2] pressed_level, [7:3] zero
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // One expected result transaction
    typedef struct packed {
        event_code_t ev;
        logic        level;
    } tick_result_t;

    tick_result_t exp_results[$];
    int unsigned  fail_cnt;
    int unsigned  ticks_sent;
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;

    // Predictor configuration and state
    bit [DEB_W-1:0]  cfg_debounce;
    bit [HOLD_W-1:0] cfg_long;
    bit [DIV_W-1:0]  cfg_ramp;
    bit              stable_lvl;
    bit [DEB_W-1:0]  mis_cnt;
    bit [HOLD_W-1:0] held_ticks;
    bit              ramp_on;
    bit [DIV_W-1:0]  step_phase;

    button_debounce_long_press_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

    // Debounce / hold / ramp update for one tick
    function automatic tick_result_t predict_tick(bit raw);
        tick_result_t r;
        r.ev = EV_NONE;
        if (raw != stable_lvl)
        begin
            mis_cnt = mis_cnt + 8'd1;
            if (mis_cnt >= cfg_debounce)
            begin
                mis_cnt    = '0;
                stable_lvl = raw;
                if (stable_lvl == LEVEL_PRESSED)
                begin
                    held_ticks = '0;
                    ramp_on    = 1'b0;
                    step_phase = '0;
                end
                else
                begin
                    r.ev    = ramp_on ? EV_LONG : EV_SHORT;
                    ramp_on = 1'b0;
                end
            end
        end
        else
            mis_cnt = '0;

        if (stable_lvl == LEVEL_PRESSED)
        begin
            if (held_ticks < HOLD_MAX)
                held_ticks = held_ticks + 16'd1;
            if (!ramp_on)
            begin
                // the tick that starts the ramp gives no step
                if (held_ticks >= cfg_long)
                begin
                    ramp_on    = 1'b1;
                    step_phase = '0;
                end
            end
            else
            begin
                step_phase = step_phase + 8'd1;
                if (step_phase >= cfg_ramp)
                begin
                    step_phase = '0;
                    r.ev       = EV_RAMP;
                end
            end
        end
        r.level = stable_lvl;
        return r;
    endfunction

    // Receiver back-pressure, redrawn every cycle
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Result checker
    always @(posedge clk)
    begin : check_results
        tick_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (exp_results.size() == 0)
            begin
                $error("unexpected result transaction, tdata %h", m_tdata);
                fail_cnt++;
            end
            else
            begin
                want = exp_results.pop_front();
                if (m_tdata[1:0] !== want.ev)
                begin
                    $error("event_code: expected %0d, got %0d", want.ev, m_tdata[1:0]);
                    fail_cnt++;
                end
                if (m_tdata[2] !== want.level)
                begin
                    $error("pressed_level: expected %0d, got %0d", want.level, m_tdata[2]);
                    fail_cnt++;
                end
                if (m_tdata[7:3] !== 5'd0)
                begin
                    $error("padding: expected 0, got %0h", m_tdata[7:3]);
                    fail_cnt++;
                end
            end
        end
    end

    // Send one tick transaction, with random idle cycles ahead of it
    task automatic send_tick(bit lvl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, lvl};
        do @(posedge clk); while (!s_tready);
        exp_results.push_back(predict_tick(lvl));
        ticks_sent++;
    endtask

    task automatic send_run(bit lvl, int unsigned n);
        repeat (n) send_tick(lvl);
    endtask

    // Stop sending and let every tick in flight come out
    task automatic drain_ticks();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (exp_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_DEBOUNCE_TICKS:   cfg_debounce = val[DEB_W-1:0];
            REG_LONG_PRESS_TICKS: cfg_long     = val[HOLD_W-1:0];
            REG_RAMP_INTERVAL:    cfg_ramp     = val[DIV_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Rewrite all three registers once the core is idle; upper data bits are junk
    task automatic set_config(bit [7:0] deb, bit [15:0] lng, bit [7:0] ramp);
        drain_ticks();
        apb_write(REG_DEBOUNCE_TICKS,   {24'($urandom_range(0, 32'hFFFFFF)), deb});
        apb_write(REG_LONG_PRESS_TICKS, {16'($urandom_range(0, 16'hFFFF)), lng});
        apb_write(REG_RAMP_INTERVAL,    {24'($urandom_range(0, 32'hFFFFFF)), ramp});
    endtask

    // Reset values: a glitch shorter than the debounce, then a short press
    task automatic test_default_config();
        send_run(LEVEL_PRESSED, 3);
        send_run(LEVEL_RELEASED, 2);
        send_run(LEVEL_PRESSED, 10);
        send_run(LEVEL_RELEASED, 4);
    endtask

    // All registers zero: instant accept, ramp on first pressed tick, step every tick
    task automatic test_zero_config();
        set_config(8'd0, 16'd0, 8'd0);
        send_run(LEVEL_PRESSED, 5);
        send_run(LEVEL_RELEASED, 3);
    endtask

    // Ramp start and steps, then a long-press release
    task automatic test_long_press();
        set_config(8'd2, 16'd5, 8'd3);
        send_run(LEVEL_PRESSED, 20);
        send_run(LEVEL_RELEASED, 2);
    endtask

    // Largest settings: press and release each need the full 255-tick streak
    task automatic test_max_config();
        set_config(8'd255, 16'hFFFF, 8'd255);
        send_run(LEVEL_PRESSED, 260);
        send_run(LEVEL_RELEASED, 255);
    endtask

    // A write to the unused index must leave the settings alone
    task automatic test_unused_register();
        set_config(8'd1, 16'd3, 8'd2);
        apb_write(REG_UNUSED, $urandom);
        send_run(LEVEL_PRESSED, 8);
        send_run(LEVEL_RELEASED, 1);
        send_run(LEVEL_PRESSED, 2);
        send_run(LEVEL_RELEASED, 1);
    endtask

    // Bounce, a held press of random length, bounce, a confirmed release
    task automatic press_cycle();
        int unsigned held;
        int unsigned rel;
        repeat ($urandom_range(0, 3)) send_tick(1'($urandom_range(0, 1)));
        held = cfg_debounce + $urandom_range(0, cfg_long + 3 * cfg_ramp + 6);
        send_run(LEVEL_PRESSED, held);
        repeat ($urandom_range(0, 3)) send_tick(1'($urandom_range(0, 1)));
        rel = ((cfg_debounce == 0) ? 1 : cfg_debounce) + $urandom_range(0, 4);
        send_run(LEVEL_RELEASED, rel);
    endtask

    // Random settings and press sequences under one idling mix
    task automatic test_random_ticks(int unsigned idle_pct, int unsigned stall_pct,
                                     int unsigned n_ticks);
        int unsigned target;
        bit [7:0]    deb;
        repeat (3)
        begin
            case ($urandom_range(0, 9))
                0:       deb = 8'd0;
                1:       deb = 8'd1;
                default: deb = 8'($urandom_range(1, 5));
            endcase
            set_config(deb, 16'($urandom_range(0, 25)), 8'($urandom_range(0, 5)));
            send_idle_pct  = idle_pct;
            recv_stall_pct = stall_pct;
            target = ticks_sent + n_ticks / 3;
            while (ticks_sent < target)
            begin
                if ($urandom_range(99) < 85)
                    press_cycle();
                else
                    repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
            end
            drain_ticks();
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        fail_cnt       = 0;
        ticks_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cfg_debounce   = DEBOUNCE_TICKS_RST;
        cfg_long       = LONG_PRESS_TICKS_RST;
        cfg_ramp       = RAMP_INTERVAL_RST;
        stable_lvl     = LEVEL_RELEASED;
        mis_cnt        = '0;
        held_ticks     = '0;
        ramp_on        = 1'b0;
        step_phase     = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_config();
        test_zero_config();
        test_long_press();
        test_max_config();
        test_unused_register();
        test_random_ticks(0, 0, 90);
        test_random_ticks(48, 0, 90);
        test_random_ticks(0, 48, 90);
        test_random_ticks(26, 26, 90);

        drain_ticks();
        repeat (10) @(posedge clk);
        if (fail_cnt == 0 && exp_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
design/bdlp_pkg.sv
design/button_debounce_long_press_core.sv
verif/tb_button_debounce_long_press_core.sv
